/* hdl/jlsd_pkg.sv */
// Shared constants and register codes for the jerk-limited stopping distance block.
package jlsd_pkg;

    localparam int MAX_STEPS = 20000;
    localparam int FRAC_BITS = 16;
    localparam int DT_W      = 16;
    localparam int VAL_W     = 32;
    localparam int LIM_W     = 31;
    localparam int DIST_W    = 31 + FRAC_BITS;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int DVD_W     = 2 * LIM_W;
    localparam int DVS_W     = VAL_W;
    localparam int DCNT_W    = $clog2(DVD_W + 1);
    localparam int CNT_W     = $clog2(MAX_STEPS + 1);
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic [LIM_W-1:0] ACCEL_RST = LIM_W'(655360);
    localparam logic [LIM_W-1:0] JERK_RST  = LIM_W'(6553600);
    localparam logic [LIM_W-1:0] VLIM_RST  = {LIM_W{1'b1}};
    localparam logic [DT_W-1:0]  DT_RST    = DT_W'(1311);

    localparam logic [1:0] REG_ACCEL = 2'd0;
    localparam logic [1:0] REG_JERK  = 2'd1;
    localparam logic [1:0] REG_VLIM  = 2'd2;
    localparam logic [1:0] REG_DT    = 2'd3;

endpackage

/* hdl/jlsd_if.sv */
// Valid/ready channel interfaces for the command and result streams.
interface jlsd_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [jlsd_pkg::VAL_W-1:0]   start_speed;
    logic signed [jlsd_pkg::VAL_W-1:0]   start_accel;
    logic                                floor_accel;

    modport source (output valid, output start_speed, output start_accel,
                    output floor_accel, input ready);
    modport sink   (input valid, input start_speed, input start_accel,
                    input floor_accel, output ready);
endinterface

interface jlsd_out_if;
    logic                          valid;
    logic                          ready;
    logic [jlsd_pkg::DIST_W-1:0]   stop_distance;

    modport source (output valid, output stop_distance, input ready);
    modport sink   (input valid, input stop_distance, output ready);
endinterface

/* hdl/jlsd_mul.sv */
// Shared unsigned multiplier with a registered product.
module jlsd_mul (
    input  logic                          i_clk,
    input  logic [jlsd_pkg::VAL_W-1:0]    i_a,
    input  logic [jlsd_pkg::VAL_W-1:0]    i_b,
    output logic [jlsd_pkg::PROD_W-1:0]   o_prod
);

    logic [jlsd_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= jlsd_pkg::PROD_W'(i_a) * jlsd_pkg::PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

/* hdl/jlsd_div.sv */
// Restoring divider that produces one quotient bit per cycle.
module jlsd_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [jlsd_pkg::DVD_W-1:0]    i_dividend,
    input  logic [jlsd_pkg::DVS_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [jlsd_pkg::DVD_W-1:0]    o_quot
);

    logic                          r_busy;
    logic                          r_done;
    logic [jlsd_pkg::DCNT_W-1:0]   r_cnt;
    logic [jlsd_pkg::DVS_W-1:0]    r_rem;
    logic [jlsd_pkg::DVS_W-1:0]    r_dvs;
    logic [jlsd_pkg::DVD_W-1:0]    r_quo;
    logic [jlsd_pkg::DVS_W:0]      trial;
    logic [jlsd_pkg::DVS_W:0]      diff;
    logic                          ge;
    logic [jlsd_pkg::DVS_W-1:0]    n_rem;

    always_comb begin
        trial = {r_rem, r_quo[jlsd_pkg::DVD_W-1]};
        ge    = trial >= {1'b0, r_dvs};
        diff  = trial - {1'b0, r_dvs};
        n_rem = ge ? diff[jlsd_pkg::DVS_W-1:0] : trial[jlsd_pkg::DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == jlsd_pkg::DCNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
            r_cnt <= jlsd_pkg::DCNT_W'(jlsd_pkg::DVD_W);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[jlsd_pkg::DVD_W-2:0], ge};
            r_cnt <= r_cnt - jlsd_pkg::DCNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

/* hdl/jerk_limited_stopping_distance.sv */
// Top level: jerk-limited stopping distance with a stepping sequencer around one multiplier.
// Sequence: S_LD and S_JT load, then each time step runs S_SQ, S_TH, S_JD, S_AN, S_AM,
// S_VN, S_AC before the jerk-down phase and S_AN, S_AM, S_VN, S_AC after it, up to MAX_STEPS
// steps; S_VV, S_DS and S_DW run when the last piece needs the 62-bit divider, then S_FIN
// loads the output register. One item at a time: a command is taken only in S_IDLE.
// Reset is synchronous and active low: it restores register defaults and idles the sequencer.
module jerk_limited_stopping_distance (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [jlsd_pkg::ADDR_W-1:0]   paddr,
    input  logic [jlsd_pkg::DATA_W-1:0]   pwdata,
    output logic [jlsd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    jlsd_in_if.sink                       i_cmd,
    jlsd_out_if.source                    o_res
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LD   = 4'd1;
    localparam logic [3:0] S_JT   = 4'd2;
    localparam logic [3:0] S_SQ   = 4'd3;
    localparam logic [3:0] S_TH   = 4'd4;
    localparam logic [3:0] S_JD   = 4'd5;
    localparam logic [3:0] S_AN   = 4'd6;
    localparam logic [3:0] S_AM   = 4'd7;
    localparam logic [3:0] S_VN   = 4'd8;
    localparam logic [3:0] S_AC   = 4'd9;
    localparam logic [3:0] S_VV   = 4'd10;
    localparam logic [3:0] S_DS   = 4'd11;
    localparam logic [3:0] S_DW   = 4'd12;
    localparam logic [3:0] S_FIN  = 4'd13;

    localparam logic signed [33:0] S32_MAX = 34'sd2147483647;
    localparam logic signed [33:0] S32_MIN = -34'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
        logic signed [33:0] y;
        begin
            y = x;
            if (x > S32_MAX) y = S32_MAX;
            if (x < S32_MIN) y = S32_MIN;
            return y[31:0];
        end
    endfunction

    function automatic logic [jlsd_pkg::DIST_W-1:0] add_dist(
        input logic [jlsd_pkg::DIST_W-1:0] d,
        input logic [jlsd_pkg::PROD_W-1:0] t
    );
        logic [jlsd_pkg::DIST_W:0] s;
        begin
            s = {1'b0, d} + {1'b0, t[jlsd_pkg::DIST_W-1:0]};
            if ((|t[jlsd_pkg::PROD_W-1:jlsd_pkg::DIST_W]) || s[jlsd_pkg::DIST_W]) begin
                return jlsd_pkg::DIST_MAX;
            end
            return s[jlsd_pkg::DIST_W-1:0];
        end
    endfunction

    logic [3:0]                        r_state;
    logic [3:0]                        n_state;
    logic [jlsd_pkg::LIM_W-1:0]        r_accel;
    logic [jlsd_pkg::LIM_W-1:0]        r_jerk;
    logic [jlsd_pkg::LIM_W-1:0]        r_vlim;
    logic [jlsd_pkg::DT_W-1:0]         r_dt;
    logic                              r_ovalid;
    logic [jlsd_pkg::DIST_W-1:0]       r_res;

    logic [jlsd_pkg::LIM_W-1:0]        r_v;
    logic signed [31:0]                r_a;
    logic [31:0]                       r_amag;
    logic                              r_jdn;
    logic [jlsd_pkg::LIM_W-1:0]        r_jdt;
    logic [jlsd_pkg::PROD_W-1:0]       r_sq;
    logic signed [31:0]                r_an;
    logic [31:0]                       r_anmag;
    logic signed [31:0]                r_vn;
    logic                              r_stop;
    logic [jlsd_pkg::CNT_W-1:0]        r_cnt;
    logic [jlsd_pkg::DIST_W-1:0]       r_acc;

    logic                              cfg_wr;
    logic                              accept;
    logic                              fin_load;
    logic signed [31:0]                a_in;
    logic [31:0]                       mul_a;
    logic [31:0]                       mul_b;
    logic [jlsd_pkg::PROD_W-1:0]       prod;
    logic                              div_start;
    logic                              div_done;
    logic [jlsd_pkg::DVD_W-1:0]        quot;
    logic signed [33:0]                target;
    logic signed [33:0]                a34;
    logic signed [33:0]                jdt34;
    logic signed [33:0]                an34;
    logic signed [31:0]                an_sat;
    logic [31:0]                       an_mag;
    logic signed [33:0]                v34;
    logic signed [33:0]                delta;
    logic signed [33:0]                vs;
    logic signed [31:0]                vn;
    logic                              stop;
    logic [jlsd_pkg::PROD_W-1:0]       add_t;
    logic [jlsd_pkg::DIST_W-1:0]       acc_sum;
    logic                              last_step;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign accept   = i_cmd.valid && i_cmd.ready;
    assign fin_load = (r_state == S_FIN) && (!r_ovalid || o_res.ready);

    assign i_cmd.ready         = (r_state == S_IDLE);
    assign o_res.valid         = r_ovalid;
    assign o_res.stop_distance = r_res;

    always_comb begin
        unique case (paddr[3:2])
            jlsd_pkg::REG_ACCEL: prdata = jlsd_pkg::DATA_W'(r_accel);
            jlsd_pkg::REG_JERK:  prdata = jlsd_pkg::DATA_W'(r_jerk);
            jlsd_pkg::REG_VLIM:  prdata = jlsd_pkg::DATA_W'(r_vlim);
            jlsd_pkg::REG_DT:    prdata = jlsd_pkg::DATA_W'(r_dt);
            default:             prdata = '0;
        endcase
    end

    assign a_in = (i_cmd.floor_accel && i_cmd.start_accel <= 0) ? 32'sd0 : i_cmd.start_accel;

    always_comb begin
        unique case (r_state)
            S_LD: begin
                mul_a = 32'(r_jerk);
                mul_b = 32'(r_dt);
            end
            S_SQ: begin
                mul_a = r_amag;
                mul_b = r_amag;
            end
            S_TH: begin
                mul_a = 32'(r_v);
                mul_b = {r_jerk, 1'b0};
            end
            S_AM: begin
                mul_a = r_anmag;
                mul_b = 32'(r_dt);
            end
            S_VN: begin
                mul_a = 32'(r_v);
                mul_b = 32'(r_dt);
            end
            S_VV: begin
                mul_a = 32'(r_v);
                mul_b = 32'(r_v);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    jlsd_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign div_start = (r_state == S_DS);

    jlsd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (prod[jlsd_pkg::DVD_W-1:0]),
        .i_divisor  (r_anmag),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // Next acceleration: ramp toward the limit, or back toward zero once jerk-down is latched.
    always_comb begin
        target = -$signed({3'b000, r_accel});
        a34    = {{2{r_a[31]}}, r_a};
        jdt34  = $signed({3'b000, r_jdt});
        if (!r_jdn) begin
            an34 = (a34 > target) ? (a34 - jdt34) : a34;
            if (an34 < target) begin
                an34 = target;
            end
        end else begin
            an34 = r_a[31] ? (a34 + jdt34) : a34;
        end
        an_sat = sat32(an34);
        an_mag = an_sat[31] ? (~an_sat + 32'd1) : an_sat;
    end

    always_comb begin
        v34   = $signed({3'b000, r_v});
        delta = $signed({3'b000, prod[jlsd_pkg::DT_W +: jlsd_pkg::LIM_W]});
        vs    = r_an[31] ? (v34 - delta) : (v34 + delta);
        if (!r_jdn && vs > $signed({3'b000, r_vlim})) begin
            vs = $signed({3'b000, r_vlim});
        end
        vn   = sat32(vs);
        stop = (vn <= 0) || (r_jdn && r_a > 0);
    end

    always_comb begin
        if (r_state == S_DW) begin
            add_t = jlsd_pkg::PROD_W'(quot);
        end else begin
            add_t = jlsd_pkg::PROD_W'(prod[jlsd_pkg::DT_W +: jlsd_pkg::LIM_W]);
        end
        acc_sum   = add_dist(r_acc, add_t);
        last_step = (r_cnt == jlsd_pkg::CNT_W'(jlsd_pkg::MAX_STEPS - 1));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) begin
                n_state = (i_cmd.start_speed <= 0) ? S_FIN : S_LD;
            end
            S_LD:   n_state = S_JT;
            S_JT:   n_state = r_jdn ? S_AN : S_SQ;
            S_SQ:   n_state = S_TH;
            S_TH:   n_state = S_JD;
            S_JD:   n_state = S_AN;
            S_AN:   n_state = S_AM;
            S_AM:   n_state = S_VN;
            S_VN:   n_state = S_AC;
            S_AC: begin
                if (r_stop && r_an[31]) begin
                    n_state = S_VV;
                end else if (r_stop || last_step) begin
                    n_state = S_FIN;
                end else begin
                    n_state = r_jdn ? S_AN : S_SQ;
                end
            end
            S_VV:   n_state = S_DS;
            S_DS:   n_state = S_DW;
            S_DW:   if (div_done) begin
                n_state = S_FIN;
            end
            S_FIN:  if (fin_load) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_accel  <= jlsd_pkg::ACCEL_RST;
            r_jerk   <= jlsd_pkg::JERK_RST;
            r_vlim   <= jlsd_pkg::VLIM_RST;
            r_dt     <= jlsd_pkg::DT_RST;
        end else begin
            r_state <= n_state;
            if (fin_load) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    jlsd_pkg::REG_ACCEL: r_accel <= pwdata[jlsd_pkg::LIM_W-1:0];
                    jlsd_pkg::REG_JERK:  r_jerk  <= pwdata[jlsd_pkg::LIM_W-1:0];
                    jlsd_pkg::REG_VLIM:  r_vlim  <= pwdata[jlsd_pkg::LIM_W-1:0];
                    jlsd_pkg::REG_DT:    r_dt    <= pwdata[jlsd_pkg::DT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (accept) begin
                r_v    <= i_cmd.start_speed[jlsd_pkg::LIM_W-1:0];
                r_a    <= a_in;
                r_amag <= a_in[31] ? (~a_in + 32'd1) : a_in;
                r_jdn  <= (r_jerk == '0);
                r_cnt  <= '0;
                r_acc  <= '0;
            end
            S_JT: r_jdt <= prod[jlsd_pkg::DT_W +: jlsd_pkg::LIM_W];
            S_TH: r_sq  <= prod;
            S_JD: r_jdn <= (prod <= r_sq);
            S_AN: begin
                r_an    <= an_sat;
                r_anmag <= an_mag;
            end
            S_VN: begin
                r_vn   <= vn;
                r_stop <= stop;
            end
            S_AC: if (!(r_stop && r_an[31])) begin
                r_acc  <= acc_sum;
                r_v    <= r_vn[jlsd_pkg::LIM_W-1:0];
                r_a    <= r_an;
                r_amag <= r_anmag;
                r_cnt  <= r_cnt + jlsd_pkg::CNT_W'(1);
            end
            S_DW: if (div_done) begin
                r_acc <= acc_sum;
            end
            S_FIN: if (fin_load) begin
                r_res <= r_acc;
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DW))
        else $error("Divider finished outside the wait state.");

    a_step_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AN) |-> (r_cnt < jlsd_pkg::CNT_W'(jlsd_pkg::MAX_STEPS)))
        else $error("Step counter passed the step cap.");

    a_speed_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AN || r_state == S_SQ) |-> (r_v != '0))
        else $error("Stepping with a speed of zero.");

    a_accel_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AM && !r_jdn) |-> ($signed({{2{r_an[31]}}, r_an}) >= target))
        else $error("Acceleration below the limit during the ramp phase.");
`endif

endmodule
